FILE: hw/rtl/kbf_pkg.sv
// shared types, constants and saturation helpers for the angle and bias kalman filter
package kbf_pkg;

    // operation codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SET    = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_ANGLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_BIAS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_R_MEASURE = 2'd2;

    // register reset values
    localparam logic [31:0] Q_ANGLE_RST   = 32'd1073742;
    localparam logic [31:0] Q_BIAS_RST    = 32'd3221225;
    localparam logic [31:0] R_MEASURE_RST = 32'd32212255;

    // covariance one in q10.30
    localparam logic signed [39:0] P_ONE = 40'sd1073741824;

    // saturation bounds on the common 48-bit working width
    localparam logic signed [47:0] S32_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] S32_MIN = -48'sh0000_8000_0000;
    localparam logic signed [47:0] S40_MAX = 48'sh007F_FFFF_FFFF;
    localparam logic signed [47:0] S40_MIN = -48'sh0080_0000_0000;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_M_ANG,
        ST_M_T,
        ST_INNER,
        ST_M_P00,
        ST_M_P11,
        ST_RESID,
        ST_DIV_K0,
        ST_DIV_K1,
        ST_M_A,
        ST_M_B,
        ST_M_P10C,
        ST_M_P11C,
        ST_M_P00C,
        ST_M_P01C,
        ST_OUT
    } state_t;

    // multiplier request
    typedef struct packed {
        logic               start;
        logic               sel30;
        logic signed [41:0] a;
        logic signed [31:0] b;
    } mul_req_t;

    // divider request
    typedef struct packed {
        logic               start;
        logic signed [39:0] num;
        logic signed [40:0] den;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [47:0] r;
        r = v;
        if (v > S32_MAX)
        begin
            r = S32_MAX;
        end
        else if (v < S32_MIN)
        begin
            r = S32_MIN;
        end
        return r[31:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
        logic signed [47:0] r;
        r = v;
        if (v > S40_MAX)
        begin
            r = S40_MAX;
        end
        else if (v < S40_MIN)
        begin
            r = S40_MIN;
        end
        return r[39:0];
    endfunction

endpackage

FILE: hw/rtl/kbf_mul.sv
// shared signed multiplier with rounding right shift, two partial products per operation
module kbf_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  kbf_pkg::mul_req_t  req,
    output logic               done,
    output logic signed [43:0] prod
);
    import kbf_pkg::*;

    logic [41:0]        ua_reg;
    logic [31:0]        ub_reg;
    logic               neg_reg;
    logic               sel_reg;
    logic [73:0]        acc_reg;
    logic [1:0]         ph_reg;
    logic               done_reg;
    logic signed [43:0] prod_reg;

    logic [41:0] a_mag;
    logic [31:0] b_mag;
    logic [20:0] part;
    logic [52:0] pp;
    logic [73:0] rnd;
    logic [73:0] shifted;
    logic [42:0] m;

    // operand magnitudes
    assign a_mag = req.a[41] ? 42'(-req.a) : 42'(req.a);
    assign b_mag = req.b[31] ? 32'(-req.b) : 32'(req.b);

    // one 21x32 partial product a cycle
    assign part = (ph_reg == 2'd1) ? ua_reg[20:0] : ua_reg[41:21];
    assign pp   = 53'(part) * 53'(ub_reg);

    // round half away from zero on the magnitude, then shift
    assign rnd     = acc_reg + (sel_reg ? (74'd1 << 29) : (74'd1 << 15));
    assign shifted = sel_reg ? (rnd >> 30) : (rnd >> 16);
    assign m       = shifted[42:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ua_reg   <= '0;
            ub_reg   <= '0;
            neg_reg  <= 1'b0;
            sel_reg  <= 1'b0;
            acc_reg  <= '0;
            ph_reg   <= 2'd0;
            done_reg <= 1'b0;
            prod_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (ph_reg)
                2'd0:
                begin
                    if (req.start)
                    begin
                        ua_reg  <= a_mag;
                        ub_reg  <= b_mag;
                        neg_reg <= req.a[41] ^ req.b[31];
                        sel_reg <= req.sel30;
                        ph_reg  <= 2'd1;
                    end
                end
                2'd1:
                begin
                    acc_reg <= 74'(pp);
                    ph_reg  <= 2'd2;
                end
                2'd2:
                begin
                    acc_reg <= acc_reg + (74'(pp) << 21);
                    ph_reg  <= 2'd3;
                end
                default:
                begin
                    prod_reg <= neg_reg ? -$signed({1'b0, m}) : $signed({1'b0, m});
                    done_reg <= 1'b1;
                    ph_reg   <= 2'd0;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

FILE: hw/rtl/kbf_div.sv
// radix-2 restoring divider for the q2.30 kalman gains
module kbf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  kbf_pkg::div_req_t  req,
    output logic               done,
    output logic signed [31:0] quot
);
    import kbf_pkg::*;

    logic [41:0]        rem_reg;
    logic [40:0]        ud_reg;
    logic [29:0]        q_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               neg_reg;
    logic               done_reg;
    logic signed [31:0] quot_reg;

    logic [39:0] un;
    logic [40:0] ud;
    logic        bit_q;
    logic [41:0] rem_sub;
    logic [30:0] qn;

    // magnitudes of numerator and denominator
    assign un = req.num[39] ? 40'(-req.num) : 40'(req.num);
    assign ud = req.den[40] ? 41'(-req.den) : 41'(req.den);

    // one quotient bit a cycle
    assign bit_q   = rem_reg >= 42'(ud_reg);
    assign rem_sub = bit_q ? (rem_reg - 42'(ud_reg)) : rem_reg;
    assign qn      = {q_reg, bit_q};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            ud_reg   <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            neg_reg  <= 1'b0;
            done_reg <= 1'b0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                rem_reg <= {rem_sub[40:0], 1'b0};
                q_reg   <= qn[29:0];
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quot_reg <= neg_reg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
                end
            end
            else if (req.start)
            begin
                neg_reg <= req.num[39] ^ req.den[40];
                ud_reg  <= ud;
                if (ud == '0)
                begin
                    // zero innovation covariance gives zero gain
                    quot_reg <= '0;
                    done_reg <= 1'b1;
                end
                else if (42'(un) >= {ud, 1'b0})
                begin
                    // gain beyond range saturates with the quotient sign
                    quot_reg <= (req.num[39] ^ req.den[40]) ? 32'sh8000_0000
                                                           : 32'sh7FFF_FFFF;
                    done_reg <= 1'b1;
                end
                else
                begin
                    rem_reg  <= 42'(un);
                    q_reg    <= '0;
                    cnt_reg  <= '0;
                    busy_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: hw/rtl/angle_bias_kalman_filter.sv
// two-state kalman filter top level: sequencer, state registers and config
//
//  channel  direction  handshake            payload
//  in       into       in_valid/in_stall    operation, measured_angle, gyro_rate, time_step
//  out      out of     out_valid/out_stall  filtered_angle
//  cfg      into       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a set-angle word or an update with zero time step goes from acceptance through the output
// state to the output register. a full update runs ten multiplies on the shared multiplier,
// two gain divisions and four steps that use neither unit; a gain that saturates or has a
// zero denominator is settled by the divider without the bit-serial loop.
// in_stall is high from acceptance until the result enters the output register.
// the output register holds its word while out_stall is high; reset leaves angle and bias
// at zero and the covariance at identity. cfg_ready is always high.
module angle_bias_kalman_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic signed [31:0]             measured_angle,
    input  logic signed [31:0]             gyro_rate,
    input  logic [15:0]                    time_step,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             filtered_angle,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);
    import kbf_pkg::*;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;

    logic [31:0] q_angle_reg, q_bias_reg, r_measure_reg;

    logic signed [31:0] angle_reg, angle_next;
    logic signed [31:0] bias_reg, bias_next;
    logic signed [39:0] p00_reg, p00_next;
    logic signed [39:0] p01_reg, p01_next;
    logic signed [39:0] p10_reg, p10_next;
    logic signed [39:0] p11_reg, p11_next;

    logic signed [31:0] meas_reg, meas_next;
    logic signed [31:0] gyro_reg, gyro_next;
    logic [15:0]        dt_reg, dt_next;
    logic signed [31:0] rate_reg, rate_next;
    logic signed [41:0] t_reg, t_next;
    logic signed [41:0] inner_reg, inner_next;
    logic signed [32:0] y_reg, y_next;
    logic signed [40:0] s_reg, s_next;
    logic signed [31:0] k0_reg, k0_next;
    logic signed [31:0] k1_reg, k1_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_angle_reg, out_angle_next;

    mul_req_t           mul_req;
    logic               mul_done;
    logic signed [43:0] mul_prod;
    div_req_t           div_req;
    logic               div_done;
    logic signed [31:0] div_quot;

    logic signed [47:0] mp;
    logic signed [31:0] dt_s;

    assign mp   = 48'(mul_prod);
    assign dt_s = $signed({16'd0, dt_reg});

    kbf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    kbf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_angle_reg   <= Q_ANGLE_RST;
            q_bias_reg    <= Q_BIAS_RST;
            r_measure_reg <= R_MEASURE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_Q_ANGLE:   q_angle_reg   <= cfg_data;
                CFG_Q_BIAS:    q_bias_reg    <= cfg_data;
                CFG_R_MEASURE: r_measure_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            angle_reg     <= '0;
            bias_reg      <= '0;
            p00_reg       <= P_ONE;
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= P_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            angle_reg     <= angle_next;
            bias_reg      <= bias_next;
            p00_reg       <= p00_next;
            p01_reg       <= p01_next;
            p10_reg       <= p10_next;
            p11_reg       <= p11_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        meas_reg      <= meas_next;
        gyro_reg      <= gyro_next;
        dt_reg        <= dt_next;
        rate_reg      <= rate_next;
        t_reg         <= t_next;
        inner_reg     <= inner_next;
        y_reg         <= y_next;
        s_reg         <= s_next;
        k0_reg        <= k0_next;
        k1_reg        <= k1_next;
        out_angle_reg <= out_angle_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        angle_next     = angle_reg;
        bias_next      = bias_reg;
        p00_next       = p00_reg;
        p01_next       = p01_reg;
        p10_next       = p10_reg;
        p11_next       = p11_reg;
        meas_next      = meas_reg;
        gyro_next      = gyro_reg;
        dt_next        = dt_reg;
        rate_next      = rate_reg;
        t_next         = t_reg;
        inner_next     = inner_reg;
        y_next         = y_reg;
        s_next         = s_reg;
        k0_next        = k0_reg;
        k1_next        = k1_reg;
        out_angle_next = out_angle_reg;
        out_valid_next = out_valid_reg && out_stall;

        mul_req.start  = 1'b0;
        mul_req.sel30  = 1'b0;
        mul_req.a      = '0;
        mul_req.b      = '0;
        div_req.start  = 1'b0;
        div_req.num    = '0;
        div_req.den    = '0;

        // operand selection for the shared units
        case (state_reg)
            ST_M_ANG:
            begin
                mul_req.a = 42'(rate_reg);
                mul_req.b = dt_s;
            end
            ST_M_T:
            begin
                mul_req.a = 42'(p11_reg);
                mul_req.b = dt_s;
            end
            ST_M_P00:
            begin
                mul_req.a = inner_reg;
                mul_req.b = dt_s;
            end
            ST_M_P11:
            begin
                mul_req.a = $signed({10'd0, q_bias_reg});
                mul_req.b = dt_s;
            end
            ST_M_A:
            begin
                mul_req.sel30 = 1'b1;
                mul_req.a     = 42'(y_reg);
                mul_req.b     = k0_reg;
            end
            ST_M_B:
            begin
                mul_req.sel30 = 1'b1;
                mul_req.a     = 42'(y_reg);
                mul_req.b     = k1_reg;
            end
            ST_M_P10C:
            begin
                mul_req.sel30 = 1'b1;
                mul_req.a     = 42'(p00_reg);
                mul_req.b     = k1_reg;
            end
            ST_M_P11C:
            begin
                mul_req.sel30 = 1'b1;
                mul_req.a     = 42'(p01_reg);
                mul_req.b     = k1_reg;
            end
            ST_M_P00C:
            begin
                mul_req.sel30 = 1'b1;
                mul_req.a     = 42'(p00_reg);
                mul_req.b     = k0_reg;
            end
            ST_M_P01C:
            begin
                mul_req.sel30 = 1'b1;
                mul_req.a     = 42'(p01_reg);
                mul_req.b     = k0_reg;
            end
            ST_DIV_K0:
            begin
                div_req.num = p00_reg;
                div_req.den = s_reg;
            end
            ST_DIV_K1:
            begin
                div_req.num = p10_reg;
                div_req.den = s_reg;
            end
            default:
            begin
            end
        endcase

        // issue one operation per step and wait for it
        case (state_reg)
            ST_M_ANG, ST_M_T, ST_M_P00, ST_M_P11, ST_M_A, ST_M_B,
            ST_M_P10C, ST_M_P11C, ST_M_P00C, ST_M_P01C:
            begin
                if (!issued_reg)
                begin
                    mul_req.start = 1'b1;
                    issued_next   = 1'b1;
                end
            end
            ST_DIV_K0, ST_DIV_K1:
            begin
                if (!issued_reg)
                begin
                    div_req.start = 1'b1;
                    issued_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    meas_next = measured_angle;
                    gyro_next = gyro_rate;
                    dt_next   = time_step;
                    if (operation == OP_SET)
                    begin
                        angle_next = measured_angle;
                        state_next = ST_OUT;
                    end
                    else if (time_step == '0)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_RATE;
                    end
                end
            end
            ST_RATE:
            begin
                rate_next  = sat32(48'(gyro_reg) - 48'(bias_reg));
                state_next = ST_M_ANG;
            end
            ST_M_ANG:
            begin
                if (mul_done)
                begin
                    angle_next  = sat32(48'(angle_reg) + mp);
                    issued_next = 1'b0;
                    state_next  = ST_M_T;
                end
            end
            ST_M_T:
            begin
                if (mul_done)
                begin
                    t_next      = mul_prod[41:0];
                    issued_next = 1'b0;
                    state_next  = ST_INNER;
                end
            end
            ST_INNER:
            begin
                inner_next = 42'(48'(t_reg) - 48'(p01_reg) - 48'(p10_reg)
                                 + $signed({16'd0, q_angle_reg}));
                p01_next   = sat40(48'(p01_reg) - 48'(t_reg));
                p10_next   = sat40(48'(p10_reg) - 48'(t_reg));
                state_next = ST_M_P00;
            end
            ST_M_P00:
            begin
                if (mul_done)
                begin
                    p00_next    = sat40(48'(p00_reg) + mp);
                    issued_next = 1'b0;
                    state_next  = ST_M_P11;
                end
            end
            ST_M_P11:
            begin
                if (mul_done)
                begin
                    p11_next    = sat40(48'(p11_reg) + mp);
                    issued_next = 1'b0;
                    state_next  = ST_RESID;
                end
            end
            ST_RESID:
            begin
                y_next     = 33'(meas_reg) - 33'(angle_reg);
                s_next     = 41'(p00_reg) + $signed({9'd0, r_measure_reg});
                state_next = ST_DIV_K0;
            end
            ST_DIV_K0:
            begin
                if (div_done)
                begin
                    k0_next     = div_quot;
                    issued_next = 1'b0;
                    state_next  = ST_DIV_K1;
                end
            end
            ST_DIV_K1:
            begin
                if (div_done)
                begin
                    k1_next     = div_quot;
                    issued_next = 1'b0;
                    state_next  = ST_M_A;
                end
            end
            ST_M_A:
            begin
                if (mul_done)
                begin
                    angle_next  = sat32(48'(angle_reg) + mp);
                    issued_next = 1'b0;
                    state_next  = ST_M_B;
                end
            end
            ST_M_B:
            begin
                if (mul_done)
                begin
                    bias_next   = sat32(48'(bias_reg) + mp);
                    issued_next = 1'b0;
                    state_next  = ST_M_P10C;
                end
            end
            ST_M_P10C:
            begin
                if (mul_done)
                begin
                    p10_next    = sat40(48'(p10_reg) - mp);
                    issued_next = 1'b0;
                    state_next  = ST_M_P11C;
                end
            end
            ST_M_P11C:
            begin
                if (mul_done)
                begin
                    p11_next    = sat40(48'(p11_reg) - mp);
                    issued_next = 1'b0;
                    state_next  = ST_M_P00C;
                end
            end
            ST_M_P00C:
            begin
                if (mul_done)
                begin
                    p00_next    = sat40(48'(p00_reg) - mp);
                    issued_next = 1'b0;
                    state_next  = ST_M_P01C;
                end
            end
            ST_M_P01C:
            begin
                if (mul_done)
                begin
                    p01_next    = sat40(48'(p01_reg) - mp);
                    issued_next = 1'b0;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // load the output word once the register is free
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    out_angle_next = angle_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign filtered_angle = out_angle_reg;

endmodule

FILE: hw/rtl/kbf_checker.sv
// port-level checks for the kalman filter, bound to the top level
module kbf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] filtered_angle
);

    // an accepted word keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input not held off after an accepted word");

    // a result only appears while a word is being worked on
    a_out_from_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall)
    ) else $error("result appeared with no word in flight");

    // a stalled result stays and holds its value
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(filtered_angle))
    ) else $error("stalled result dropped or changed");

endmodule

bind angle_bias_kalman_filter kbf_checker u_kbf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_angle (filtered_angle)
);
